FILE: src/page_replacement_policy_engine_macros.svh
// Assertion macros used by the page replacement engine checker.
`ifndef PAGE_REPLACEMENT_POLICY_ENGINE_MACROS_SVH
`define PAGE_REPLACEMENT_POLICY_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PRPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define PRPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: src/prpe_pkg.sv
// Package with types and constants of the page replacement engine.
`default_nettype none

package prpe_pkg;

    localparam int PROCESSES_DEF = 4;
    localparam int CAPACITY_DEF  = 16;
    localparam int PAGE_BITS_DEF = 16;

    localparam int PID_W     = 2;
    localparam int TIME_W    = 16;
    localparam int FREQ_W    = 16;
    localparam int FAULT_W   = 16;
    localparam int CNT_OUT_W = 5;
    localparam int LIMIT_W   = 5;
    localparam int LIMIT_REGS = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT3 = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
    localparam int SET_NONE = 31;
    localparam logic [FREQ_W-1:0]  FREQ_MAX  = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef enum logic [1:0] {
        POL_LIFO = 2'd0,
        POL_MRU  = 2'd1,
        POL_LRU  = 2'd2,
        POL_LFU  = 2'd3
    } t_policy;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_SHIFT,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic evict;
        logic shift;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic evict_need;
        logic shift_done;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: src/page_replacement_policy_engine.sv
// Top level of the page replacement policy engine.
`default_nettype none

// Page replacement policy engine. Each item is one page reference (process,
// page, time) and is taken when start is high while busy is low. The engine
// looks the page up in that process's resident list; a hit refreshes the
// entry's access time and frequency, a miss evicts a victim when the list is
// at its limit (newest insert, most recent, least recent or least frequent
// access, ties to the oldest insert) and appends the new page. Exactly one
// result follows every item: o_valid is high for one cycle with the result
// fields, and the receiver cannot stall it, so it must capture the result in
// that cycle. The entries live in one single-port-read memory, and that port
// sets the rate: busy stays high while the scan reads the process's entries
// one after another (stopping early on a hit) and, when an eviction has to
// close the gap in the list, while every entry behind the victim is copied
// down one slot per cycle. A new item may be started in the cycle in which
// busy falls. The entry memory is not cleared after reset; only slots below
// a process's resident count are ever read. Configuration writes (policy
// and the four limits) are taken at once and belong in idle periods.

module page_replacement_policy_engine #(
    parameter int PROCESSES = prpe_pkg::PROCESSES_DEF,
    parameter int CAPACITY  = prpe_pkg::CAPACITY_DEF,
    parameter int PAGE_BITS = prpe_pkg::PAGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [prpe_pkg::PID_W-1:0]      i_process_id,
    input  logic [PAGE_BITS-1:0]            i_page_number,
    input  logic [prpe_pkg::TIME_W-1:0]     i_access_time,
    input  logic                            i_cfg_we,
    input  logic [prpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_valid,
    output logic                            o_hit,
    output logic                            o_evicted_valid,
    output logic [PAGE_BITS-1:0]            o_evicted_page,
    output logic [prpe_pkg::FAULT_W-1:0]    o_fault_count,
    output logic [prpe_pkg::CNT_OUT_W-1:0]  o_resident_count,
    output logic [prpe_pkg::CNT_OUT_W-1:0]  o_min_workset,
    output logic [prpe_pkg::CNT_OUT_W-1:0]  o_max_workset
);
    import prpe_pkg::*;

    t_policy          r_policy;
    logic [LIMIT_W-1:0] r_limit [LIMIT_REGS];
    t_dp_cmd          cmd;
    t_dp_status       status;

    // Configuration registers. Writes to an index past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_LIFO;
            for (int k = 0; k < LIMIT_REGS; k++) begin
                r_limit[k] <= LIMIT_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POLICY: r_policy   <= t_policy'(i_cfg_data[1:0]);
                REG_LIMIT0: r_limit[0] <= i_cfg_data;
                REG_LIMIT1: r_limit[1] <= i_cfg_data;
                REG_LIMIT2: r_limit[2] <= i_cfg_data;
                REG_LIMIT3: r_limit[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The sequencer steps the item through scan, eviction, shift and commit.
    prpe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // The datapath holds the entries and the per-process counters.
    prpe_datapath #(
        .PROCESSES (PROCESSES),
        .CAPACITY  (CAPACITY),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_policy         (r_policy),
        .i_limit          (r_limit),
        .i_process_id     (i_process_id),
        .i_page_number    (i_page_number),
        .i_access_time    (i_access_time),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_page   (o_evicted_page),
        .o_fault_count    (o_fault_count),
        .o_resident_count (o_resident_count),
        .o_min_workset    (o_min_workset),
        .o_max_workset    (o_max_workset)
    );

endmodule

`default_nettype wire

FILE: src/prpe_ctrl.sv
// Sequencer of the page replacement engine.
`default_nettype none

module prpe_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  prpe_pkg::t_dp_status  i_status,
    output prpe_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy
);
    import prpe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = i_status.evict_need ? ST_EVICT : ST_COMMIT;
                end
            end
            ST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = ST_SHIFT;
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.shift_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

FILE: src/prpe_datapath.sv
// Datapath of the page replacement engine: entry memory, scan and shift logic.
`default_nettype none

module prpe_datapath #(
    parameter int PROCESSES = prpe_pkg::PROCESSES_DEF,
    parameter int CAPACITY  = prpe_pkg::CAPACITY_DEF,
    parameter int PAGE_BITS = prpe_pkg::PAGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  prpe_pkg::t_dp_cmd                  i_cmd,
    output prpe_pkg::t_dp_status               o_status,
    input  prpe_pkg::t_policy                  i_policy,
    input  logic [prpe_pkg::LIMIT_W-1:0]       i_limit [prpe_pkg::LIMIT_REGS],
    input  logic [prpe_pkg::PID_W-1:0]         i_process_id,
    input  logic [PAGE_BITS-1:0]               i_page_number,
    input  logic [prpe_pkg::TIME_W-1:0]        i_access_time,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic                               o_evicted_valid,
    output logic [PAGE_BITS-1:0]               o_evicted_page,
    output logic [prpe_pkg::FAULT_W-1:0]       o_fault_count,
    output logic [prpe_pkg::CNT_OUT_W-1:0]     o_resident_count,
    output logic [prpe_pkg::CNT_OUT_W-1:0]     o_min_workset,
    output logic [prpe_pkg::CNT_OUT_W-1:0]     o_max_workset
);
    import prpe_pkg::*;

    localparam int PW     = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int SW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DEPTH  = PROCESSES * CAPACITY;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SMW    = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
    localparam int WORD_W = PAGE_BITS + FREQ_W + TIME_W;
    localparam int LIMCMP_W = 8;

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p,
                                              input logic [SW-1:0] slot);
        addr_of = AW'(AW'(p) * AW'(CAPACITY)) + AW'(slot);
    endfunction

    // Entry memory: one word per slot of every process.
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // Per-process bookkeeping.
    logic [CW-1:0]      r_resident [PROCESSES];
    logic [FAULT_W-1:0] r_faults   [PROCESSES];
    logic [SMW-1:0]     r_small    [PROCESSES];
    logic [SMW-1:0]     r_large    [PROCESSES];

    // Item registers.
    logic [PW-1:0]        r_p;
    logic [PAGE_BITS-1:0] r_page;
    logic [TIME_W-1:0]    r_time;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_lim;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_ridx;
    logic                 r_rvalid;
    logic                 r_hit;
    logic [CW-1:0]        r_hit_idx;
    logic [FREQ_W-1:0]    r_hit_freq;
    logic [CW-1:0]        r_best_idx;
    logic [TIME_W-1:0]    r_best_key;
    logic [PAGE_BITS-1:0] r_best_page;
    logic                 r_ev;
    logic [PAGE_BITS-1:0] r_ev_page;

    logic [PAGE_BITS-1:0] rd_page;
    logic [FREQ_W-1:0]    rd_freq;
    logic [TIME_W-1:0]    rd_last;
    logic [TIME_W-1:0]    rd_key;
    logic                 better;
    logic                 issue;
    logic [PW-1:0]        in_p;
    logic [PID_W:0]       pid_ext;
    logic [LIMCMP_W-1:0]  lim_raw;
    logic [CW-1:0]        lim_eff;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [WORD_W-1:0]    wdata;
    logic [CW-1:0]        n_count;
    logic [CW-1:0]        app_slot;
    logic [FREQ_W-1:0]    hit_freq_inc;
    logic [FAULT_W-1:0]   n_faults;
    logic [SMW-1:0]       n_small;
    logic [SMW-1:0]       n_large;

    assign rd_page = r_rdata[WORD_W-1 -: PAGE_BITS];
    assign rd_freq = r_rdata[TIME_W +: FREQ_W];
    assign rd_last = r_rdata[TIME_W-1:0];
    assign rd_key  = (i_policy == POL_LFU) ? rd_freq : rd_last;

    // Process id folded into range; the id is below twice any count above one.
    always_comb begin
        pid_ext = {1'b0, i_process_id};
        if (PROCESSES == 1) begin
            in_p = '0;
        end else if (32'(pid_ext) >= 32'(PROCESSES)) begin
            in_p = PW'(32'(pid_ext) - 32'(PROCESSES));
        end else begin
            in_p = PW'(pid_ext);
        end
    end

    // Limit register chosen by the low two bits of the process, then clamped.
    always_comb begin
        lim_raw = LIMCMP_W'(i_limit[2'(LIMCMP_W'(in_p))]);
        if (lim_raw == '0) begin
            lim_eff = CW'(1);
        end else if (lim_raw > LIMCMP_W'(CAPACITY)) begin
            lim_eff = CW'(CAPACITY);
        end else begin
            lim_eff = CW'(lim_raw);
        end
    end

    always_comb begin
        unique case (i_policy)
            POL_LIFO: better = 1'b1;
            POL_MRU:  better = (rd_key > r_best_key);
            POL_LRU:  better = (rd_key < r_best_key);
            POL_LFU:  better = (rd_key < r_best_key);
            default:  better = 1'b0;
        endcase
    end

    assign issue = ((i_cmd.scan && !r_hit) || i_cmd.shift) && (r_idx < r_n);

    assign o_status.scan_done  = !r_rvalid && ((r_idx >= r_n) || r_hit);
    assign o_status.shift_done = !r_rvalid && (r_idx >= r_n);
    assign o_status.evict_need = !r_hit && (r_n >= r_lim) && (r_n != '0);

    assign hit_freq_inc = (r_hit_freq < FREQ_MAX) ? r_hit_freq + FREQ_W'(1) : r_hit_freq;
    assign app_slot     = r_ev ? r_n - CW'(1) : r_n;
    assign n_count      = (r_hit || r_ev) ? r_n : r_n + CW'(1);

    // Memory write port: shift copies or the final entry update.
    always_comb begin
        we    = 1'b0;
        waddr = addr_of(r_p, app_slot[SW-1:0]);
        wdata = {r_page, FREQ_W'(1), r_time};
        if (i_cmd.shift && r_rvalid) begin
            we    = 1'b1;
            waddr = addr_of(r_p, SW'(r_ridx - CW'(1)));
            wdata = r_rdata;
        end else if (i_cmd.commit) begin
            we = 1'b1;
            if (r_hit) begin
                waddr = addr_of(r_p, r_hit_idx[SW-1:0]);
                wdata = {r_page, hit_freq_inc, r_time};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[addr_of(r_p, r_idx[SW-1:0])];
    end

    always_comb begin
        n_faults = r_faults[r_p];
        n_small  = r_small[r_p];
        n_large  = r_large[r_p];
        if (r_hit) begin
            if (SMW'(r_n) < n_small) begin
                n_small = SMW'(r_n);
            end
            if (SMW'(r_n) > n_large) begin
                n_large = SMW'(r_n);
            end
        end else if (n_faults < FAULT_MAX) begin
            n_faults = n_faults + FAULT_W'(1);
        end
    end

    // Control registers of the sequenced item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
            r_hit    <= 1'b0;
            r_ev     <= 1'b0;
            r_idx    <= '0;
            o_valid  <= 1'b0;
            for (int k = 0; k < PROCESSES; k++) begin
                r_resident[k] <= '0;
                r_faults[k]   <= '0;
                r_small[k]    <= SMW'(SET_NONE);
                r_large[k]    <= '0;
            end
        end else begin
            o_valid  <= i_cmd.commit;
            r_rvalid <= issue;
            if (issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.load) begin
                r_hit <= 1'b0;
                r_ev  <= 1'b0;
                r_idx <= '0;
            end
            if (i_cmd.scan && r_rvalid && !r_hit && (rd_page == r_page)) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.evict) begin
                r_ev  <= 1'b1;
                r_idx <= r_best_idx + CW'(1);
            end
            if (i_cmd.commit) begin
                r_resident[r_p] <= n_count;
                r_faults[r_p]   <= n_faults;
                r_small[r_p]    <= n_small;
                r_large[r_p]    <= n_large;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_ridx <= r_idx;
        end
        if (i_cmd.load) begin
            r_p    <= in_p;
            r_page <= i_page_number;
            r_time <= i_access_time;
            r_lim  <= lim_eff;
            r_n    <= (r_resident[in_p] > CW'(CAPACITY)) ? CW'(CAPACITY) : r_resident[in_p];
        end
        if (i_cmd.scan && r_rvalid) begin
            if (!r_hit && (rd_page == r_page)) begin
                r_hit_idx  <= r_ridx;
                r_hit_freq <= rd_freq;
            end
            if ((r_ridx == '0) || better) begin
                r_best_idx  <= r_ridx;
                r_best_key  <= rd_key;
                r_best_page <= rd_page;
            end
        end
        if (i_cmd.evict) begin
            r_ev_page <= r_best_page;
        end
        if (i_cmd.commit) begin
            o_hit            <= r_hit;
            o_evicted_valid  <= r_ev;
            o_evicted_page   <= r_ev ? r_ev_page : '0;
            o_fault_count    <= n_faults;
            o_resident_count <= CNT_OUT_W'(n_count);
            o_min_workset    <= CNT_OUT_W'(n_small);
            o_max_workset    <= CNT_OUT_W'(n_large);
        end
    end

endmodule

`default_nettype wire

FILE: src/prpe_checker.sv
// Port-level checker of the page replacement engine and its bind.
`default_nettype none

`include "page_replacement_policy_engine_macros.svh"

module prpe_checker #(
    parameter int PAGE_BITS = prpe_pkg::PAGE_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input logic                 o_hit,
    input logic                 o_evicted_valid,
    input logic [PAGE_BITS-1:0] o_evicted_page
);

    // An accepted item keeps the engine busy in the following cycle.
    `PRPE_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)

    // A result appears only once the engine has finished the item.
    `PRPE_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)

    // The result strobe lasts a single cycle.
    `PRPE_ASSERT_NXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)

    // A hit never evicts.
    `PRPE_ASSERT_IMP(a_hit_no_evict, i_clk, i_rst_n, o_valid && o_hit, !o_evicted_valid)

    // Without a victim the evicted page reads zero.
    `PRPE_ASSERT_IMP(a_no_evict_zero, i_clk, i_rst_n, o_valid && !o_evicted_valid,
                     o_evicted_page == '0)

endmodule

bind page_replacement_policy_engine prpe_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_prpe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_page  (o_evicted_page)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the page replacement policy engine.
`timescale 1ns / 100ps

module testbench;
    import prpe_pkg::*;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every input of the engine starts at a known value.
    logic                  start = 1'b0;
    logic                  busy;
    logic [PID_W-1:0]      i_process_id = '0;
    logic [15:0]           i_page_number = '0;
    logic [TIME_W-1:0]     i_access_time = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_POLICY;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    logic                  o_hit;
    logic                  o_evicted_valid;
    logic [15:0]           o_evicted_page;
    logic [FAULT_W-1:0]    o_fault_count;
    logic [CNT_OUT_W-1:0]  o_resident_count;
    logic [CNT_OUT_W-1:0]  o_min_workset;
    logic [CNT_OUT_W-1:0]  o_max_workset;

    page_replacement_policy_engine uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_process_id     (i_process_id),
        .i_page_number    (i_page_number),
        .i_access_time    (i_access_time),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_page   (o_evicted_page),
        .o_fault_count    (o_fault_count),
        .o_resident_count (o_resident_count),
        .o_min_workset    (o_min_workset),
        .o_max_workset    (o_max_workset)
    );

    // One outcome of a page reference, as the engine should report it.
    typedef struct packed {
        logic                 hit;
        logic                 ev_valid;
        logic [15:0]          ev_page;
        logic [FAULT_W-1:0]   faults;
        logic [CNT_OUT_W-1:0] resident;
        logic [CNT_OUT_W-1:0] min_set;
        logic [CNT_OUT_W-1:0] max_set;
    } t_outcome;

    // A row of the directed table: either a register write or a page
    // reference, the latter with an optional hand-written expectation.
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [PID_W-1:0]      pid;
        logic [15:0]           page;
        logic [15:0]           stamp;
        bit                    has_hand;
        t_outcome              hand;
    } t_row;

    // Shadow copy of the engine's page tables and counters.
    logic [15:0]        pg_page[4][16];
    logic [15:0]        pg_freq[4][16];
    logic [15:0]        pg_seen[4][16];
    int unsigned        resident_n[4];
    logic [15:0]        fault_tally[4];
    int unsigned        set_low[4];
    int unsigned        set_high[4];
    t_policy            cur_policy = POL_LIFO;
    logic [LIMIT_W-1:0] limit_reg[4] = '{default: LIMIT_RESET};

    t_outcome pending_outcomes[$];
    t_row     rows[$];
    int       errors = 0;
    int       idle_cycles = 0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t: mismatch: %s", $realtime, what);
    endtask

    // Appends one row to the directed table.
    function automatic void add_row(input t_row r);
        rows = {rows, r};
    endfunction

    // Works out what one page reference does to the shadow state.
    function automatic t_outcome reference_page(input logic [1:0] p, input logic [15:0] page,
                                                input logic [15:0] stamp);
        t_outcome    r;
        int unsigned n, lim, i, v;
        int          found;
        n     = resident_n[p];
        lim   = 32'(limit_reg[p]);
        found = -1;
        r     = '0;
        // A zero limit behaves as one, anything above the table size as full size.
        if (lim == 0) lim = 1;
        if (lim > 16) lim = 16;
        for (i = 0; i < n; i++) begin
            if (found < 0 && pg_page[p][i] == page) found = int'(i);
        end
        if (found >= 0) begin
            r.hit = 1'b1;
            pg_seen[p][found] = stamp;
            if (pg_freq[p][found] != 16'hFFFF) pg_freq[p][found]++;
            if (n < set_low[p]) set_low[p] = n;
            if (n > set_high[p]) set_high[p] = n;
        end else begin
            if (n >= lim && n > 0) begin
                // Victim search; strict comparisons keep ties on the oldest insert.
                v = 0;
                if (cur_policy == POL_LIFO) v = n - 1;
                else begin
                    for (i = 1; i < n; i++) begin
                        case (cur_policy)
                            POL_MRU: if (pg_seen[p][i] > pg_seen[p][v]) v = i;
                            POL_LRU: if (pg_seen[p][i] < pg_seen[p][v]) v = i;
                            default: if (pg_freq[p][i] < pg_freq[p][v]) v = i;
                        endcase
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = pg_page[p][v];
                for (i = v; i + 1 < n; i++) begin
                    pg_page[p][i] = pg_page[p][i+1];
                    pg_freq[p][i] = pg_freq[p][i+1];
                    pg_seen[p][i] = pg_seen[p][i+1];
                end
                n--;
            end
            if (n < 16) begin
                pg_page[p][n] = page;
                pg_freq[p][n] = 16'd1;
                pg_seen[p][n] = stamp;
                n++;
            end
            if (fault_tally[p] != FAULT_MAX) fault_tally[p]++;
        end
        resident_n[p] = n;
        r.faults   = fault_tally[p];
        r.resident = n[CNT_OUT_W-1:0];
        r.min_set  = set_low[p][CNT_OUT_W-1:0];
        r.max_set  = set_high[p][CNT_OUT_W-1:0];
        return r;
    endfunction

    // Checks each strobed result against the oldest pending outcome.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result arrived with no item outstanding");
            end else begin
                want = pending_outcomes.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch($sformatf("hit %b, want %b", o_hit, want.hit));
                if (o_evicted_valid !== want.ev_valid)
                    report_mismatch($sformatf("evicted_valid %b, want %b",
                                              o_evicted_valid, want.ev_valid));
                if (o_evicted_page !== want.ev_page)
                    report_mismatch($sformatf("evicted_page %h, want %h",
                                              o_evicted_page, want.ev_page));
                if (o_fault_count !== want.faults)
                    report_mismatch($sformatf("fault_count %0d, want %0d",
                                              o_fault_count, want.faults));
                if (o_resident_count !== want.resident)
                    report_mismatch($sformatf("resident_count %0d, want %0d",
                                              o_resident_count, want.resident));
                if (o_min_workset !== want.min_set)
                    report_mismatch($sformatf("min_workset %0d, want %0d",
                                              o_min_workset, want.min_set));
                if (o_max_workset !== want.max_set)
                    report_mismatch($sformatf("max_workset %0d, want %0d",
                                              o_max_workset, want.max_set));
            end
        end
    end

    // Watchdog: a long stretch with neither an item taken nor a result
    // strobed means the engine has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Presents one reference and holds it until the engine takes it. Called
    // right after a rising edge; returns at the edge that accepted the item,
    // so the next call may keep start high without dropping it.
    task automatic issue_reference(input logic [1:0] p, input logic [15:0] page,
                                   input logic [15:0] stamp, input bit has_hand,
                                   input t_outcome hand);
        t_outcome got;
        start         <= 1'b1;
        i_process_id  <= p;
        i_page_number <= page;
        i_access_time <= stamp;
        do @(posedge i_clk); while (busy);
        got = reference_page(p, page, stamp);
        if (has_hand && got !== hand)
            report_mismatch($sformatf("shadow model disagrees with table row, page %h", page));
        pending_outcomes = {pending_outcomes, got};
    endtask

    // Register writes only happen once the engine is idle and nothing is owed.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0 || busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_POLICY) cur_policy = t_policy'(val[1:0]);
        else limit_reg[idx - REG_LIMIT0] = val;
    endtask

    function automatic t_row ref_row(input logic [1:0] p, input logic [15:0] page,
                                     input logic [15:0] stamp);
        t_row r;
        r = '{default: '0};
        r.pid = p; r.page = page; r.stamp = stamp;
        return r;
    endfunction

    function automatic t_row hand_row(input logic [1:0] p, input logic [15:0] page,
                                      input logic [15:0] stamp, input t_outcome o);
        t_row r;
        r = ref_row(p, page, stamp);
        r.has_hand = 1'b1;
        r.hand = o;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1; r.reg_idx = idx; r.reg_val = val;
        return r;
    endfunction

    initial begin
        t_outcome    none;
        logic [15:0] pool_base, page, stamp;
        logic [1:0]  p;
        int          item_no, gap, phase, k;

        none = '0;
        for (int q = 0; q < 4; q++) begin
            resident_n[q] = 0; fault_tally[q] = '0; set_low[q] = SET_NONE; set_high[q] = 0;
        end

        // Directed part. Rows with a hand-written outcome are the ones that
        // can be read straight off the rules; the rest rely on the shadow model.
        add_row(hand_row(2'd0, 16'h0000, 16'h0000,
                         '{1'b0, 1'b0, 16'h0, 16'd1, 5'd1, 5'd31, 5'd0}));
        add_row(hand_row(2'd0, 16'h0000, 16'h0005,
                         '{1'b1, 1'b0, 16'h0, 16'd1, 5'd1, 5'd1, 5'd1}));
        add_row(hand_row(2'd3, 16'hFFFF, 16'hFFFF,
                         '{1'b0, 1'b0, 16'h0, 16'd1, 5'd1, 5'd31, 5'd0}));
        // A zero limit acts as one, so the next miss must push out the old page.
        add_row(cfg_row(REG_LIMIT0, 5'd0));
        add_row(hand_row(2'd0, 16'h0001, 16'h0001,
                         '{1'b0, 1'b1, 16'h0, 16'd2, 5'd1, 5'd1, 5'd1}));
        add_row(cfg_row(REG_LIMIT0, 5'd31));
        add_row(ref_row(2'd1, 16'd10, 16'd10));
        add_row(ref_row(2'd1, 16'd11, 16'd20));
        add_row(ref_row(2'd1, 16'd12, 16'd30));
        add_row(ref_row(2'd1, 16'd11, 16'd50));
        add_row(cfg_row(REG_LIMIT1, 5'd3));
        add_row(cfg_row(REG_POLICY, CFG_DATA_W'(POL_MRU)));
        add_row(ref_row(2'd1, 16'd13, 16'd60));
        add_row(cfg_row(REG_POLICY, CFG_DATA_W'(POL_LRU)));
        add_row(ref_row(2'd1, 16'd14, 16'd5));
        add_row(cfg_row(REG_POLICY, CFG_DATA_W'(POL_LFU)));
        add_row(ref_row(2'd1, 16'd12, 16'd70));
        add_row(ref_row(2'd1, 16'd12, 16'd71));
        add_row(ref_row(2'd1, 16'd15, 16'd80));
        add_row(cfg_row(REG_POLICY, CFG_DATA_W'(POL_LIFO)));
        add_row(ref_row(2'd1, 16'd16, 16'd90));
        // Limit lowered under the current count: one eviction, count holds.
        add_row(cfg_row(REG_LIMIT1, 5'd1));
        add_row(ref_row(2'd1, 16'd17, 16'd95));
        add_row(cfg_row(REG_LIMIT2, 5'd2));
        add_row(ref_row(2'd2, 16'h8000, 16'h8000));
        add_row(ref_row(2'd2, 16'h7FFF, 16'h7FFF));
        add_row(ref_row(2'd2, 16'h5555, 16'hAAAA));
        add_row(cfg_row(REG_LIMIT3, 5'd16));
        add_row(ref_row(2'd3, 16'hFFFF, 16'h0000));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].is_cfg) write_register(rows[r].reg_idx, rows[r].reg_val);
            else issue_reference(rows[r].pid, rows[r].page, rows[r].stamp,
                                 rows[r].has_hand, rows[r].hand);
        end

        // Random part: eight settings, the first two at the limit extremes.
        // Pages come mostly from a small pool per setting so that hits,
        // full lists and evictions all happen often.
        item_no = 0;
        stamp   = 16'd100;
        for (phase = 0; phase < 8; phase++) begin
            write_register(REG_POLICY, CFG_DATA_W'(phase % 4));
            for (k = 0; k < LIMIT_REGS; k++) begin
                if (phase == 0) write_register(CFG_IDX_W'(REG_LIMIT0 + k), 5'd1);
                else if (phase == 1) write_register(CFG_IDX_W'(REG_LIMIT0 + k), 5'd16);
                else if ($urandom_range(0, 9) == 0)
                    write_register(CFG_IDX_W'(REG_LIMIT0 + k),
                                   CFG_DATA_W'($urandom_range(0, 31)));
                else write_register(CFG_IDX_W'(REG_LIMIT0 + k),
                                    CFG_DATA_W'($urandom_range(1, 16)));
            end
            pool_base = 16'($urandom);
            for (int j = 0; j < 118; j++) begin
                p = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) page = 16'($urandom);
                else page = pool_base + 16'($urandom_range(0, 23));
                case ($urandom_range(0, 19))
                    0: stamp = 16'($urandom);
                    1: stamp = 16'hFFFF;
                    2: stamp = 16'h0000;
                    default: stamp = stamp + 16'($urandom_range(0, 3));
                endcase
                // Sender gaps, except for one long back-to-back stretch.
                if ((item_no < 300 || item_no >= 520) && $urandom_range(0, 99) < 12) begin
                    gap = $urandom_range(1, 6);
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                issue_reference(p, page, stamp, 1'b0, none);
                item_no++;
            end
        end
        start <= 1'b0;

        // Drain: every item owes exactly one result, then a short settle time.
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
